### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/awosc_pkg.sv
`default_nettype none

package awosc_pkg;

  // default build parameters
  localparam int DEF_TABLE_BITS = 12;
  localparam int DEF_MAX_OSC    = 16;

  // field and register widths
  localparam int ROOT_W     = 24;
  localparam int SAMPLE_W   = 16;
  localparam int ROM_W      = 16;
  localparam int FRAC_BITS  = 20;
  localparam int NUM_OSC_W  = 5;
  localparam int SCALE_W    = 24;
  localparam int RATIO_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // shared multiplier: signed operands, full product
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // output scaling
  localparam int GAIN_SHIFT = 15;
  localparam int ROUND_HALF = 16384;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  // register reset values
  localparam logic [NUM_OSC_W-1:0] RST_NUM_OSC     = 5'd4;
  localparam logic [SCALE_W-1:0]   RST_PHASE_SCALE = 24'd1558268;
  localparam logic [RATIO_W-1:0]   RST_BASE_RATIO  = 16'd4600;
  localparam logic [GAIN_W-1:0]    RST_OUTPUT_GAIN = 16'd8192;

  // cosine generation, Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_Q30    = 64'sd536870912;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_OSC     = 2'd0,
    CFG_PHASE_SCALE = 2'd1,
    CFG_BASE_RATIO  = 2'd2,
    CFG_OUTPUT_GAIN = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_RD,
    ST_ROM0,
    ST_ROM1,
    ST_MUL_LO,
    ST_INC,
    ST_ACC,
    ST_GAIN,
    ST_ROUND
  } state_t;

  // cos(pi/2 * m / 2^qbits) in Q1.15, Taylor series to x^16
  function automatic logic signed [ROM_W-1:0] quarter_cos(input longint m, input int qbits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    x    = (HALF_PI_Q30 * m) >>> qbits;
    x2   = (x * x) >>> 30;
    term = ONE_Q30;
    sum  = ONE_Q30;
    term = ((term * x2) >>> 30) / 2;   sum = sum - term;
    term = ((term * x2) >>> 30) / 12;  sum = sum + term;
    term = ((term * x2) >>> 30) / 30;  sum = sum - term;
    term = ((term * x2) >>> 30) / 56;  sum = sum + term;
    term = ((term * x2) >>> 30) / 90;  sum = sum - term;
    term = ((term * x2) >>> 30) / 132; sum = sum + term;
    term = ((term * x2) >>> 30) / 182; sum = sum - term;
    term = ((term * x2) >>> 30) / 240; sum = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    r = (sum * 32768 + HALF_Q30) >>> 30;
    if (r > 32767) begin
      r = 32767;
    end
    return ROM_W'(r);
  endfunction

  // full-period entry k of a 2^tbits cosine table, by quadrant symmetry
  function automatic logic signed [ROM_W-1:0] cos_entry(input int k, input int tbits);
    int qb;
    int quarter;
    int q;
    int rr;
    logic signed [ROM_W-1:0] v;
    qb      = tbits - 2;
    quarter = 1 << qb;
    q       = k >> qb;
    rr      = k & (quarter - 1);
    case (q)
      0:       v = quarter_cos(longint'(rr), qb);
      1:       v = -quarter_cos(longint'(quarter - rr), qb);
      2:       v = -quarter_cos(longint'(rr), qb);
      default: v = quarter_cos(longint'(quarter - rr), qb);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/additive_wavetable_osc_bank.sv
`default_nettype none

// Additive cosine oscillator bank. Each input transaction carries one root
// frequency (signed Q16.8 Hz) and produces exactly one output transaction:
// the sum of min(num_osc, MAX_OSC) interpolated cosine oscillators, scaled by
// output_gain, rounded and saturated to Q1.15. Oscillator i steps by
// base_ratio*(i+1)*root*phase_scale table entries per sample. Each active
// oscillator passes through PH_RD, ROM0, ROM1, MUL_LO, INC and ACC in turn,
// then the item goes through GAIN and ROUND. This sequencing comes from a
// single shared 25x25 signed multiplier (four products per oscillator plus
// one for the gain) and the one-read-port cosine ROM (two reads per
// oscillator). in_stall stays high from acceptance until the result is
// loaded into the output register; a result waiting on out_stall does not
// block the next input, but the following result waits in its final state
// until the register frees up.
// Phases reset to zero through per-oscillator valid bits, so there is no
// clearing pass. Configuration writes are meant for idle periods only.
module additive_wavetable_osc_bank
  import awosc_pkg::*;
#(
  parameter int TABLE_BITS = DEF_TABLE_BITS,
  parameter int MAX_OSC    = DEF_MAX_OSC
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ROOT_W-1:0]     root_hz,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   sample_out
);

  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int PW         = TABLE_BITS + FRAC_BITS;            // phase width
  localparam int OSC_CW     = $clog2(MAX_OSC + 1);               // count width
  localparam int OSC_IW     = (MAX_OSC > 1) ? $clog2(MAX_OSC) : 1;
  localparam int CMP_W      = (OSC_CW > NUM_OSC_W) ? OSC_CW : NUM_OSC_W;
  localparam int H_W        = RATIO_W + OSC_CW;                  // base_ratio*(i+1)
  localparam int F_W        = H_W + ROOT_W;                      // h*|root|
  localparam int ACC_W      = ROM_W + OSC_CW;

  // configuration registers
  logic [NUM_OSC_W-1:0] num_osc;
  logic [SCALE_W-1:0]   phase_scale;
  logic [RATIO_W-1:0]   base_ratio;
  logic [GAIN_W-1:0]    output_gain;

  state_t state, state_next;

  logic [OSC_CW-1:0]  osc;
  logic [OSC_CW-1:0]  osc_inc;
  logic [OSC_IW-1:0]  osc_i;
  logic [OSC_CW-1:0]  active;
  logic [CMP_W-1:0]   num_ext;

  logic               accept;
  logic               out_load;
  logic               ph_we;

  // per-item datapath
  logic [ROOT_W-1:0]  root_mag;
  logic               neg;
  logic [H_W-1:0]     h;
  logic [PW-1:0]      ph;
  logic [PW-1:0]      ph_new;
  logic [PW-1:0]      phase_sel;
  logic [SCALE_W-1:0] fl;
  logic [PW-1:0]      inc_hi;
  logic [PW-1:0]      inc;
  logic signed [ROM_W-1:0] r1;
  logic signed [ROM_W-1:0] r2;
  logic signed [ROM_W:0]   diff;
  logic signed [ROM_W:0]   interp;
  logic signed [ACC_W-1:0] acc;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // output rounding
  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [SAMPLE_W-1:0] sat;

  // phase memory, valid bits stand in for the all-zero reset
  logic [PW-1:0]      phase_mem [MAX_OSC];
  logic [MAX_OSC-1:0] phase_vld;
  logic [PW-1:0]      phase_q;
  logic               vld_q;

  // cosine ROM, registered read
  logic signed [ROM_W-1:0] cos_tab [TABLE_SIZE];
  logic [TABLE_BITS-1:0]   rom_addr;
  logic signed [ROM_W-1:0] rom_q;

  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cos
    localparam logic signed [ROM_W-1:0] COS_VAL = cos_entry(k, TABLE_BITS);
    assign cos_tab[k] = COS_VAL;
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      num_osc     <= RST_NUM_OSC;
      phase_scale <= RST_PHASE_SCALE;
      base_ratio  <= RST_BASE_RATIO;
      output_gain <= RST_OUTPUT_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_OSC:     num_osc     <= cfg_data[NUM_OSC_W-1:0];
        CFG_PHASE_SCALE: phase_scale <= cfg_data[SCALE_W-1:0];
        CFG_BASE_RATIO:  base_ratio  <= cfg_data[RATIO_W-1:0];
        CFG_OUTPUT_GAIN: output_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // num_osc above MAX_OSC clamps to MAX_OSC
  assign num_ext = CMP_W'(num_osc);
  assign active  = (num_ext > CMP_W'(MAX_OSC)) ? OSC_CW'(MAX_OSC) : num_ext[OSC_CW-1:0];

  assign osc_i   = osc[OSC_IW-1:0];
  assign osc_inc = osc + OSC_CW'(1);

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign phase_sel = vld_q ? phase_q : '0;
  assign ph_new    = neg ? (ph - inc) : (ph + inc);

  // rom[idx+1] - rom[idx], and floor(diff*frac / 2^20) from the product
  assign diff   = {r2[ROM_W-1], r2} - {r1[ROM_W-1], r1};
  assign interp = $signed(prod[FRAC_BITS+ROM_W:FRAC_BITS]);

  // round half up, then saturate to Q1.15
  assign rnd     = prod + PROD_W'(ROUND_HALF);
  assign shifted = rnd >>> GAIN_SHIFT;

  always_comb begin
    if (shifted > PROD_W'(SAT_MAX)) begin
      sat = SAMPLE_W'(SAT_MAX);
    end else if (shifted < PROD_W'(SAT_MIN)) begin
      sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per oscillator: PH_RD reads the phase, ROM0/ROM1 fetch both neighbors,
  // the multiplier runs h*|root|, f_hi*scale, f_lo*scale, diff*frac.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rom_addr   = ph[PW-1 -: TABLE_BITS];
    out_load   = 1'b0;
    ph_we      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (active == '0) ? ST_GAIN : ST_PH_RD;
        end
      end
      ST_PH_RD: begin
        state_next = ST_ROM0;
      end
      ST_ROM0: begin
        rom_addr   = phase_sel[PW-1 -: TABLE_BITS];
        mul_a      = MUL_W'(h);
        mul_b      = MUL_W'(root_mag);
        state_next = ST_ROM1;
      end
      ST_ROM1: begin
        rom_addr   = ph[PW-1 -: TABLE_BITS] + TABLE_BITS'(1);
        mul_a      = MUL_W'(prod[F_W-1:SCALE_W]);
        mul_b      = MUL_W'(phase_scale);
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_a      = MUL_W'(fl);
        mul_b      = MUL_W'(phase_scale);
        state_next = ST_INC;
      end
      ST_INC: begin
        mul_a      = MUL_W'(diff);
        mul_b      = MUL_W'(ph[FRAC_BITS-1:0]);
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ph_we      = 1'b1;
        state_next = (osc_inc == active) ? ST_GAIN : ST_PH_RD;
      end
      ST_GAIN: begin
        mul_a      = MUL_W'(acc);
        mul_b      = MUL_W'(output_gain);
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        // keep the gain product in place while the output register is busy
        mul_a = MUL_W'(acc);
        mul_b = MUL_W'(output_gain);
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rom_q <= cos_tab[rom_addr];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          neg      <= root_hz[ROOT_W-1];
          root_mag <= root_hz[ROOT_W-1] ? (~root_hz + ROOT_W'(1)) : root_hz;
          acc      <= '0;
          h        <= '0;
        end
      end
      ST_PH_RD:  h <= h + H_W'(base_ratio);
      ST_ROM0:   ph <= phase_sel;
      ST_ROM1: begin
        r1 <= rom_q;
        fl <= prod[SCALE_W-1:0];
      end
      ST_MUL_LO: begin
        r2     <= rom_q;
        inc_hi <= prod[PW-1:0];
      end
      ST_INC:    inc <= inc_hi + PW'(prod[2*SCALE_W-1:SCALE_W]);
      ST_ACC:    acc <= acc + ACC_W'(r1) + ACC_W'(interp);
      ST_ROUND: begin
        if (out_load) begin
          sample_out <= sat;
        end
      end
      default: ;
    endcase
  end

  // oscillator counter
  always_ff @(posedge clk) begin
    if (rst) begin
      osc <= '0;
    end else if (accept) begin
      osc <= '0;
    end else if (state == ST_ACC) begin
      osc <= osc_inc;
    end
  end

  // phase memory
  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[osc_i] <= ph_new;
    end
    phase_q <= phase_mem[osc_i];
    vld_q   <= phase_vld[osc_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_vld <= '0;
    end else if (ph_we) begin
      phase_vld[osc_i] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/awosc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module awosc_checker
  import awosc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] sample_out
);

  // a stalled result stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(sample_out))

  // the bank is busy right after taking a transaction
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a new result only ever comes out of a busy bank
  `ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind additive_wavetable_osc_bank awosc_checker u_awosc_checker (.*);

`default_nettype wire
